FILE: src/ssnf_pkg.sv
package ssnf_pkg;

    // request codes on the mode field
    typedef enum logic [1:0] {
        REQ_DEC   = 2'd0,
        REQ_POINT = 2'd1,
        REQ_HEX   = 2'd2
    } t_req;

    // special segment patterns, gfedcba with bit 7 as the point
    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_MINUS = 8'h40;
    localparam logic [7:0] SEG_POINT = 8'h80;

    // per-beat control that rides along with the data
    typedef struct packed {
        logic       hex;
        logic       point;
        logic       neg;
        logic [1:0] frac;
    } t_ctl;

    // stage 1 result: decoded control and magnitude
    typedef struct packed {
        t_ctl        ctl;
        logic [15:0] mag;
    } t_s1;

    // digit stage result: four digits, index 0 is least significant
    typedef struct packed {
        t_ctl           ctl;
        logic [3:0][3:0] dig;
        logic           lost;
    } t_digits;

    // hex digit to segment font
    function automatic logic [7:0] seg_font(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'h0: s = 8'h3F;
            4'h1: s = 8'h06;
            4'h2: s = 8'h5B;
            4'h3: s = 8'h4F;
            4'h4: s = 8'h66;
            4'h5: s = 8'h6D;
            4'h6: s = 8'h7D;
            4'h7: s = 8'h07;
            4'h8: s = 8'h7F;
            4'h9: s = 8'h6F;
            4'hA: s = 8'h77;
            4'hB: s = 8'h7C;
            4'hC: s = 8'h39;
            4'hD: s = 8'h5E;
            4'hE: s = 8'h79;
            4'hF: s = 8'h71;
        endcase
        return s;
    endfunction

endpackage

FILE: src/ssnf_decode.sv
module ssnf_decode
    import ssnf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_value_bits,
    input  logic [1:0]  i_fraction_digits,
    output logic        o_valid,
    output t_s1         o_s1
);

    logic r_valid;
    t_s1  r_s1;
    t_s1  n_s1;

    // mode decode; unused code 3 falls to hex
    always_comb begin
        n_s1           = '0;
        n_s1.ctl.frac  = i_fraction_digits;
        case (i_req_type)
            REQ_DEC: begin
                n_s1.ctl.neg = i_value_bits[15];
            end
            REQ_POINT: begin
                n_s1.ctl.neg   = i_value_bits[15];
                n_s1.ctl.point = 1'b1;
            end
            default: begin
                n_s1.ctl.hex = 1'b1;
            end
        endcase
        // two's complement magnitude; 0x8000 maps to itself
        n_s1.mag = n_s1.ctl.neg ? (16'd0 - i_value_bits) : i_value_bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

FILE: src/ssnf_bcd.sv
module ssnf_bcd
    import ssnf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_s1     i_s1,
    output logic    o_valid,
    output t_digits o_dig
);

    // reciprocal constants: /100 exact below 43699, /100 on q<1000, /10 below 1024
    localparam logic [12:0] RCP100_A = 13'd5243;  // >> 19
    localparam logic [5:0]  RCP100_B = 6'd41;     // >> 12
    localparam logic [7:0]  RCP10    = 8'd205;    // >> 11
    localparam logic [6:0]  C100     = 7'd100;
    localparam logic [3:0]  C10      = 4'd10;

    logic [5:2] r_v;

    // stage 2: quotient by 100
    t_ctl        r2_ctl;
    logic [15:0] r2_mag;
    logic [9:0]  r2_q100;
    logic [28:0] p2;

    // stage 3: low pair, quotient by 10000
    t_ctl        r3_ctl;
    logic [15:0] r3_mag;
    logic [6:0]  r3_lo;
    logic [9:0]  r3_q100;
    logic [3:0]  r3_q10k;
    logic [16:0] p3a;
    logic [15:0] p3b;

    // stage 4: middle pair, tens of low pair
    t_ctl        r4_ctl;
    logic [15:0] r4_mag;
    logic [6:0]  r4_lo;
    logic [6:0]  r4_mid;
    logic [3:0]  r4_tens_lo;
    logic        r4_lost;
    logic [10:0] p4a;
    logic [14:0] p4b;

    // stage 5: ones of low pair, tens of middle pair
    t_ctl        r5_ctl;
    logic [15:0] r5_mag;
    logic [3:0]  r5_ones_lo;
    logic [3:0]  r5_tens_lo;
    logic [6:0]  r5_mid;
    logic [3:0]  r5_tens_mid;
    logic        r5_lost;
    logic [7:0]  p5a;
    logic [14:0] p5b;

    // stage 6: ones of middle pair, digit select
    t_digits     r6_dig;
    t_digits     n6_dig;
    logic        r6_valid;
    logic [7:0]  p6;

    assign p2  = 29'(i_s1.mag) * 29'(RCP100_A);
    assign p3a = 17'(r2_q100) * 17'(C100);
    assign p3b = 16'(r2_q100) * 16'(RCP100_B);
    assign p4a = 11'(r3_q10k) * 11'(C100);
    assign p4b = 15'(r3_lo) * 15'(RCP10);
    assign p5a = 8'(r4_tens_lo) * 8'(C10);
    assign p5b = 15'(r4_mid) * 15'(RCP10);
    assign p6  = 8'(r5_tens_mid) * 8'(C10);

    always_comb begin
        n6_dig.ctl  = r5_ctl;
        n6_dig.lost = !r5_ctl.hex && r5_lost;
        if (r5_ctl.hex) begin
            n6_dig.dig = r5_mag;
        end else begin
            n6_dig.dig[3] = r5_tens_mid;
            n6_dig.dig[2] = r5_mid[3:0] - p6[3:0];
            n6_dig.dig[1] = r5_tens_lo;
            n6_dig.dig[0] = r5_ones_lo;
        end
    end

    // valid bits follow the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= '0;
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r_v      <= {r_v[4:2], i_valid};
            r6_valid <= r_v[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_ctl      <= i_s1.ctl;
            r2_mag      <= i_s1.mag;
            r2_q100     <= p2[28:19];

            r3_ctl      <= r2_ctl;
            r3_mag      <= r2_mag;
            r3_lo       <= r2_mag[6:0] - p3a[6:0];
            r3_q100     <= r2_q100;
            r3_q10k     <= p3b[15:12];

            r4_ctl      <= r3_ctl;
            r4_mag      <= r3_mag;
            r4_lo       <= r3_lo;
            r4_mid      <= r3_q100[6:0] - p4a[6:0];
            r4_tens_lo  <= p4b[14:11];
            r4_lost     <= (r3_q10k != 4'd0);

            r5_ctl      <= r4_ctl;
            r5_mag      <= r4_mag;
            r5_ones_lo  <= r4_lo[3:0] - p5a[3:0];
            r5_tens_lo  <= r4_tens_lo;
            r5_mid      <= r4_mid;
            r5_tens_mid <= p5b[14:11];
            r5_lost     <= r4_lost;

            r6_dig      <= n6_dig;
        end
    end

    assign o_valid = r6_valid;
    assign o_dig   = r6_dig;

endmodule

FILE: src/ssnf_format.sv
module ssnf_format
    import ssnf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_digits    i_dig,
    output logic       o_valid,
    output logic [7:0] o_digit_0,
    output logic [7:0] o_digit_1,
    output logic [7:0] o_digit_2,
    output logic [7:0] o_digit_3,
    output logic       o_truncated
);

    logic            r_valid;
    logic [3:0][7:0] r_seg;
    logic            r_trunc;
    logic [3:0][7:0] n_seg;
    logic            n_trunc;
    logic [2:0]      ndig;
    logic [2:0]      cnt;
    logic [2:0]      pad;

    // significant digit count, padding and sign placement
    always_comb begin
        priority if (i_dig.dig[3] != 4'd0) ndig = 3'd4;
        else if (i_dig.dig[2] != 4'd0)     ndig = 3'd3;
        else if (i_dig.dig[1] != 4'd0)     ndig = 3'd2;
        else if (i_dig.dig[0] != 4'd0)     ndig = 3'd1;
        else                               ndig = 3'd0;

        pad = 3'(i_dig.ctl.frac) + 3'd1;
        cnt = i_dig.lost ? 3'd4 : ndig;
        if (i_dig.ctl.point && (pad > cnt)) begin
            cnt = pad;
        end

        for (int k = 0; k < 4; k++) begin
            if (3'(k) < cnt) begin
                n_seg[k] = seg_font(i_dig.dig[k]);
            end else if (i_dig.ctl.neg && (3'(k) == cnt)) begin
                n_seg[k] = SEG_MINUS;
            end else begin
                n_seg[k] = SEG_BLANK;
            end
            if (i_dig.ctl.point && (2'(k) == i_dig.ctl.frac)) begin
                n_seg[k] = n_seg[k] | SEG_POINT;
            end
        end

        n_trunc = i_dig.lost || (i_dig.ctl.neg && (cnt == 3'd4));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_seg   <= n_seg;
            r_trunc <= n_trunc;
        end
    end

    assign o_valid     = r_valid;
    assign o_digit_0   = r_seg[3];
    assign o_digit_1   = r_seg[2];
    assign o_digit_2   = r_seg[1];
    assign o_digit_3   = r_seg[0];
    assign o_truncated = r_trunc;

endmodule

FILE: src/seven_segment_number_formatter.sv
// Four-digit seven-segment formatter.
// Input channel: i_valid / o_stall carry one beat of mode, 16-bit value and
// fraction digit count; a beat is taken on a clock edge with i_valid high and
// o_stall low. Output channel: o_valid / i_stall carry four segment bytes
// (o_digit_0 leftmost) and the truncated flag.
// Throughput: one beat per cycle while the output is not stalled. Stages
// from input beat to o_valid: decode/negate, divide by 100, split low pair
// and divide by 10000, split middle pair, two stages of tens/ones split,
// then the formatting stage that drives the output registers.
// Decimal digits use constant reciprocal multiplies, at most one per stage.
// When the receiver holds i_stall while o_valid is high, the whole pipeline
// freezes and o_stall is raised; nothing is dropped or repeated, and bubbles
// in the pipeline are not squeezed out.
// Reset (synchronous, active low) clears all valid bits; data registers are
// not reset.
module seven_segment_number_formatter
    import ssnf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_value_bits,
    input  logic [1:0]  i_fraction_digits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_digit_0,
    output logic [7:0]  o_digit_1,
    output logic [7:0]  o_digit_2,
    output logic [7:0]  o_digit_3,
    output logic        o_truncated
);

    logic    en;
    logic    s1_valid;
    t_s1     s1;
    logic    dig_valid;
    t_digits dig;

    // global advance: hold everything while the output beat is stalled
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    ssnf_decode u_decode (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (en),
        .i_valid           (i_valid),
        .i_req_type        (i_req_type),
        .i_value_bits      (i_value_bits),
        .i_fraction_digits (i_fraction_digits),
        .o_valid           (s1_valid),
        .o_s1              (s1)
    );

    ssnf_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s1_valid),
        .i_s1    (s1),
        .o_valid (dig_valid),
        .o_dig   (dig)
    );

    ssnf_format u_format (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (dig_valid),
        .i_dig       (dig),
        .o_valid     (o_valid),
        .o_digit_0   (o_digit_0),
        .o_digit_1   (o_digit_1),
        .o_digit_2   (o_digit_2),
        .o_digit_3   (o_digit_3),
        .o_truncated (o_truncated)
    );

    // truncation means all four positions hold digits
    a_trunc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_truncated) |-> (o_digit_0 != SEG_BLANK && o_digit_0 != SEG_MINUS))
        else $error("truncated beat with a free leftmost position");

    // a minus sign never lands in the rightmost position
    a_no_minus_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_digit_3 & ~SEG_POINT) != SEG_MINUS))
        else $error("minus sign in rightmost position");

    // input back-pressure only comes from a held output beat
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output back-pressure");

endmodule

FILE: test/tb_seven_segment_number_formatter.sv
module tb_seven_segment_number_formatter;
    import ssnf_pkg::*;

    // spare selector code, shown as hex by the block
    localparam logic [1:0] REQ_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 950;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 20;

    // segment glyphs for 0..F, index 0 in the low byte
    localparam logic [15:0][7:0] GLYPHS = {
        8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
        8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    typedef struct packed {
        logic [1:0]  req;
        logic [15:0] value;
        logic [1:0]  frac;
        logic        drain;     // wait for all results before showing this one
    } t_number;

    // seg[0] is the leftmost position
    typedef struct packed {
        logic [0:3][7:0] seg;
        logic            trunc;
    } t_display;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_req_type;
    logic [15:0] i_value_bits;
    logic [1:0]  i_fraction_digits;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_digit_0;
    logic [7:0]  o_digit_1;
    logic [7:0]  o_digit_2;
    logic [7:0]  o_digit_3;
    logic        o_truncated;

    t_number  numbers_to_show[$];
    t_display expected_displays[$];
    int       mismatch_count;
    int       beats_sent;
    int       total_numbers;
    int       cycle_count;
    int       sender_idle_pct;
    int       receiver_stall_pct;

    seven_segment_number_formatter DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_req_type        (i_req_type),
        .i_value_bits      (i_value_bits),
        .i_fraction_digits (i_fraction_digits),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_digit_0         (o_digit_0),
        .o_digit_1         (o_digit_1),
        .o_digit_2         (o_digit_2),
        .o_digit_3         (o_digit_3),
        .o_truncated       (o_truncated)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // expected segment bytes for one number
    function automatic t_display format_number(logic [1:0] req, logic [15:0] value,
                                               logic [1:0] frac);
        t_display    disp;
        int unsigned mag;
        int unsigned base;
        int unsigned pad;
        int          pos;
        logic        neg;
        disp = '0;
        neg  = 1'b0;
        pad  = 0;
        pos  = 3;
        if (req == REQ_DEC || req == REQ_POINT) begin
            base = 10;
            neg  = value[15];
            mag  = neg ? (32'h10000 - value) : value;
            if (req == REQ_POINT)
                pad = frac + 1;
        end else begin
            base = 16;
            mag  = value;
        end
        // digits from the right, least significant first
        while (mag > 0 && pos >= 0) begin
            disp.seg[2'(pos)] = GLYPHS[4'(mag % base)];
            pos--;
            mag = mag / base;
            if (pad > 0)
                pad--;
        end
        disp.trunc = (mag > 0);
        // zero padding up to the point
        while (pad > 0 && pos >= 0) begin
            disp.seg[2'(pos)] = GLYPHS[0];
            pos--;
            pad--;
        end
        if (neg) begin
            if (pos >= 0 && !disp.trunc)
                disp.seg[2'(pos)] = SEG_MINUS;
            else
                disp.trunc = 1'b1;
        end
        if (req == REQ_POINT)
            disp.seg[2'd3 - frac] |= SEG_POINT;
        return disp;
    endfunction

    task automatic flag_mismatch(string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic add_number(logic [1:0] req, logic [15:0] value, logic [1:0] frac,
                              logic drain);
        t_number num;
        num.req   = req;
        num.value = value;
        num.frac  = frac;
        num.drain = drain;
        numbers_to_show.push_back(num);
    endtask

    // random number with a bias toward values that fit and edge values
    task automatic add_random_number(logic drain);
        logic [15:0] value;
        int          kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: value = 16'($urandom_range(0, 65535));
            4, 5, 6: value = 16'($urandom_range(0, 999));
            7: value = 16'($urandom_range(0, 9999));
            8: value = 16'($urandom_range(0, 255));
            default: begin
                case ($urandom_range(0, 5))
                    0: value = 16'h7FFF;
                    1: value = 16'h8000;
                    2: value = 16'd9999;
                    3: value = 16'd10000;
                    4: value = 16'd1000;
                    default: value = 16'hFFFF;
                endcase
            end
        endcase
        // negate half of the small magnitudes
        if (kind >= 4 && kind <= 8 && $urandom_range(0, 1))
            value = -value;
        add_number(2'($urandom_range(0, 3)), value, 2'($urandom_range(0, 3)), drain);
    endtask

    // sender: present the next number, hold it while stalled
    always @(posedge i_clk) begin : drive_beats
        t_number  next_num;
        logic     show;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                next_num = numbers_to_show.pop_front();
                expected_displays.push_back(format_number(next_num.req, next_num.value,
                                                          next_num.frac));
                beats_sent++;
            end
            if (!i_valid || !o_stall) begin
                show = numbers_to_show.size() > 0
                       && $urandom_range(0, 99) >= sender_idle_pct;
                if (show && numbers_to_show[0].drain && expected_displays.size() > 0)
                    show = 1'b0;
                if (show) begin
                    next_num          = numbers_to_show[0];
                    i_req_type        <= next_num.req;
                    i_value_bits      <= next_num.value;
                    i_fraction_digits <= next_num.frac;
                end
                i_valid <= show;
            end
            // idling profile by progress through the run
            if (beats_sent < total_numbers / 3) begin
                sender_idle_pct    <= 11;
                receiver_stall_pct <= 78;
            end else if (beats_sent < 2 * total_numbers / 3) begin
                sender_idle_pct    <= 78;
                receiver_stall_pct <= 11;
            end else begin
                sender_idle_pct    <= 0;
                receiver_stall_pct <= 0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    // check each result beat against the oldest expected display
    always @(posedge i_clk) begin : check_beats
        t_display        want;
        logic [0:3][7:0] got;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_displays.size() == 0) begin
                flag_mismatch("result beat with no number outstanding");
            end else begin
                want = expected_displays.pop_front();
                got  = {o_digit_0, o_digit_1, o_digit_2, o_digit_3};
                for (int k = 0; k < 4; k++) begin
                    if (got[2'(k)] !== want.seg[2'(k)])
                        flag_mismatch($sformatf("digit_%0d got %02h want %02h",
                                                k, got[2'(k)], want.seg[2'(k)]));
                end
                if (o_truncated !== want.trunc)
                    flag_mismatch($sformatf("truncated got %0b want %0b",
                                            o_truncated, want.trunc));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_stall            = 1'b0;
        i_req_type         = REQ_DEC;
        i_value_bits       = '0;
        i_fraction_digits  = '0;
        mismatch_count     = 0;
        beats_sent         = 0;
        cycle_count        = 0;
        sender_idle_pct    = 11;
        receiver_stall_pct = 78;

        // zero: blank without a point, padded with a point
        add_number(REQ_DEC, 16'd0, 2'd3, 1'b0);
        add_number(REQ_HEX, 16'd0, 2'd0, 1'b0);
        add_number(REQ_POINT, 16'd0, 2'd0, 1'b0);
        add_number(REQ_POINT, 16'd0, 2'd3, 1'b0);
        // plain decimal, sign placement and lost digits or sign
        add_number(REQ_DEC, 16'd1, 2'd0, 1'b0);
        add_number(REQ_DEC, 16'hFFFF, 2'd0, 1'b0);
        add_number(REQ_DEC, 16'd9999, 2'd1, 1'b0);
        add_number(REQ_DEC, 16'd12345, 2'd2, 1'b0);
        add_number(REQ_DEC, 16'h7FFF, 2'd0, 1'b0);
        add_number(REQ_DEC, 16'h8000, 2'd0, 1'b0);
        add_number(REQ_DEC, -16'sd999, 2'd0, 1'b0);
        add_number(REQ_DEC, -16'sd1000, 2'd0, 1'b0);
        // point mode: padding, sign with and without room
        add_number(REQ_POINT, -16'sd5, 2'd2, 1'b0);
        add_number(REQ_POINT, 16'd12345, 2'd3, 1'b0);
        add_number(REQ_POINT, -16'sd1, 2'd3, 1'b0);
        add_number(REQ_POINT, 16'd7, 2'd1, 1'b0);
        add_number(REQ_POINT, -16'sd42, 2'd0, 1'b0);
        // hex, including the spare selector
        add_number(REQ_HEX, 16'hFFFF, 2'd3, 1'b0);
        add_number(REQ_HEX, 16'h0010, 2'd1, 1'b0);
        add_number(REQ_HEX, 16'hABCD, 2'd2, 1'b0);
        add_number(REQ_SPARE, 16'h1234, 2'd3, 1'b0);
        add_number(REQ_SPARE, 16'h0000, 2'd0, 1'b0);

        // random part; pause for a full drain now and then
        for (int n = 0; n < RANDOM_ITEMS; n++)
            add_random_number(n == 0 || n == 400);
        total_numbers = numbers_to_show.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (numbers_to_show.size() != 0)
            @(posedge i_clk);
        while (expected_displays.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
